// ----- design/cps_pkg.sv -----
`default_nettype none

package cps_pkg;

	// Collider kind codes.
	localparam logic [1:0] KIND_BOX    = 2'd1;
	localparam logic [1:0] KIND_CIRCLE = 2'd2;

	// Root of a 64-bit square gives 32 bits, one bit per stage.
	localparam int unsigned SQ_STEPS  = 32;
	// Quotient of the scaled component is at most 2^32, so 33 bits.
	localparam int unsigned DIV_STEPS = 33;
	localparam int unsigned NUM_W     = 65;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_BB,
		MODE_CB,
		MODE_CC
	} mode_t;

	// Per-item context that rides along the root and divide pipelines.
	typedef struct packed {
		logic               hit;
		logic               flip;
		logic               rnd;
		logic               neg_x;
		logic               neg_y;
		logic               len_zero;
		logic signed [33:0] ax_px;
		logic signed [33:0] ax_py;
		logic [31:0]        a;
		logic [31:0]        b;
		logic [31:0]        r;
	} ctx_t;

endpackage

`default_nettype wire

// ----- design/cps_front.sv -----
`default_nettype none

module cps_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [1:0]         mover_kind,
	input  wire logic signed [31:0] mover_center_x,
	input  wire logic signed [31:0] mover_center_y,
	input  wire logic [30:0]        mover_extent_x,
	input  wire logic [30:0]        mover_extent_y,
	input  wire logic [1:0]         fixed_kind,
	input  wire logic signed [31:0] fixed_center_x,
	input  wire logic signed [31:0] fixed_center_y,
	input  wire logic [30:0]        fixed_extent_x,
	input  wire logic [30:0]        fixed_extent_y,
	output logic                    out_valid,
	output cps_pkg::ctx_t           out_ctx,
	output logic [63:0]             out_rad
);
	import cps_pkg::*;

	// Stage 1 signals.
	logic               m_box, m_circ, f_box, f_circ, flip_c;
	mode_t              mode_c;
	logic signed [31:0] cx, cy, bx, by;
	logic [30:0]        cre, cey, hx_c, hy_c;
	logic               v_s1, flip_s1;
	mode_t              mode_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic [31:0]        sumx_s1, sumy_s1, rr_s1;
	logic [30:0]        hx_s1, hy_s1;

	// Stage 2 signals.
	logic               v_s2, flip_s2, negx_s2, negy_s2;
	mode_t              mode_s2;
	logic [32:0]        adx_s2, ady_s2;
	logic signed [33:0] penx_s2, peny_s2;
	logic [30:0]        hx_s2, hy_s2;
	logic [31:0]        rr_s2;

	// Stage 3 signals.
	logic               pen_ok, corner, reject;
	ctx_t               ctx_c3;
	logic               v_s3;
	ctx_t               ctx_s3;

	// Stage 4 and 5 signals.
	logic               v_s4;
	ctx_t               ctx_s4;
	logic [63:0]        a2_s4, b2_s4, r2_s4;
	logic [64:0]        sum_c5;
	ctx_t               ctx_c5;

	// Pick the pair mode and order the pair as circle (or mover) against box.
	always_comb begin
		m_box  = (mover_kind == KIND_BOX);
		m_circ = (mover_kind == KIND_CIRCLE);
		f_box  = (fixed_kind == KIND_BOX);
		f_circ = (fixed_kind == KIND_CIRCLE);
		flip_c = m_box & f_circ;
		if (m_box & f_box) begin
			mode_c = MODE_BB;
		end else if ((m_circ & f_box) | flip_c) begin
			mode_c = MODE_CB;
		end else if (m_circ & f_circ) begin
			mode_c = MODE_CC;
		end else begin
			mode_c = MODE_NONE;
		end
		cx   = flip_c ? fixed_center_x : mover_center_x;
		cy   = flip_c ? fixed_center_y : mover_center_y;
		bx   = flip_c ? mover_center_x : fixed_center_x;
		by   = flip_c ? mover_center_y : fixed_center_y;
		cre  = flip_c ? fixed_extent_x : mover_extent_x;
		cey  = flip_c ? fixed_extent_y : mover_extent_y;
		hx_c = flip_c ? mover_extent_x : fixed_extent_x;
		hy_c = flip_c ? mover_extent_y : fixed_extent_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid <= v_s4;
		end
	end

	// Stage 1: center differences and extent sums.
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode_c;
			flip_s1 <= flip_c;
			dx_s1   <= 33'(cx) - 33'(bx);
			dy_s1   <= 33'(cy) - 33'(by);
			sumx_s1 <= 32'(cre) + 32'(hx_c);
			sumy_s1 <= 32'((mode_c == MODE_BB) ? cey : cre) + 32'(hy_c);
			rr_s1   <= (mode_c == MODE_CC) ? (32'(cre) + 32'(hx_c)) : 32'(cre);
			hx_s1   <= hx_c;
			hy_s1   <= hy_c;
		end
	end

	// Stage 2: magnitudes and penetration depths.
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			flip_s2 <= flip_s1;
			negx_s2 <= dx_s1[32];
			negy_s2 <= dy_s1[32];
			adx_s2  <= dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
			ady_s2  <= dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
			penx_s2 <= signed'(34'(sumx_s1))
				- signed'(34'(dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1)));
			peny_s2 <= signed'(34'(sumy_s1))
				- signed'(34'(dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1)));
			hx_s2   <= hx_s1;
			hy_s2   <= hy_s1;
			rr_s2   <= rr_s1;
		end
	end

	// Stage 3 logic: zone tests, axis push and round-path operands.
	always_comb begin
		pen_ok = (penx_s2 > 34'sd0) && (peny_s2 > 34'sd0);
		corner = (mode_s2 == MODE_CB) && (adx_s2 >= 33'(hx_s2)) && (ady_s2 >= 33'(hy_s2));
		reject = (adx_s2 >= 33'(rr_s2)) || (ady_s2 >= 33'(rr_s2));
		ctx_c3          = '0;
		ctx_c3.flip     = flip_s2;
		ctx_c3.neg_x    = negx_s2;
		ctx_c3.neg_y    = negy_s2;
		ctx_c3.r        = rr_s2;
		ctx_c3.hit      = ((mode_s2 == MODE_BB) || (mode_s2 == MODE_CB)) && pen_ok && !corner;
		ctx_c3.rnd      = ((mode_s2 == MODE_CC) && !reject) || (corner && pen_ok);
		if (mode_s2 == MODE_CC) begin
			ctx_c3.a = 32'(adx_s2);
			ctx_c3.b = 32'(ady_s2);
		end else begin
			ctx_c3.a = 32'(adx_s2 - 33'(hx_s2));
			ctx_c3.b = 32'(ady_s2 - 33'(hy_s2));
		end
		if (peny_s2 <= penx_s2) begin
			ctx_c3.ax_px = '0;
			ctx_c3.ax_py = negy_s2 ? -peny_s2 : peny_s2;
		end else begin
			ctx_c3.ax_px = negx_s2 ? -penx_s2 : penx_s2;
			ctx_c3.ax_py = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3 <= ctx_c3;
		end
	end

	// Stage 4: squares of the offsets and of the reach.
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4 <= ctx_s3;
			a2_s4  <= 64'(ctx_s3.a) * 64'(ctx_s3.a);
			b2_s4  <= 64'(ctx_s3.b) * 64'(ctx_s3.b);
			r2_s4  <= 64'(ctx_s3.r) * 64'(ctx_s3.r);
		end
	end

	// Stage 5: squared distance against squared reach.
	always_comb begin
		sum_c5     = 65'(a2_s4) + 65'(b2_s4);
		ctx_c5     = ctx_s4;
		ctx_c5.hit = ctx_s4.hit | (ctx_s4.rnd & (sum_c5 < 65'(r2_s4)));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ctx <= ctx_c5;
			out_rad <= sum_c5[63:0];
		end
	end

endmodule

`default_nettype wire

// ----- design/cps_sqrt.sv -----
`default_nettype none

module cps_sqrt (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire cps_pkg::ctx_t in_ctx,
	input  wire logic [63:0]   rad,
	output logic               out_valid,
	output cps_pkg::ctx_t      out_ctx,
	output logic [31:0]        root
);
	import cps_pkg::*;

	logic        v_s    [1:SQ_STEPS];
	ctx_t        ctx_s  [1:SQ_STEPS];
	logic [63:0] rem_s  [1:SQ_STEPS];
	logic [31:0] root_s [1:SQ_STEPS];

	// One root bit per stage, most significant first.
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam int unsigned Bit = SQ_STEPS - 1 - k;
		logic        v_i;
		ctx_t        ctx_i;
		logic [63:0] rem_i;
		logic [31:0] root_i;
		logic [65:0] trial;
		logic        take;

		if (k == 0) begin : g_first
			assign v_i    = in_valid;
			assign ctx_i  = in_ctx;
			assign rem_i  = rad;
			assign root_i = '0;
		end else begin : g_next
			assign v_i    = v_s[k];
			assign ctx_i  = ctx_s[k];
			assign rem_i  = rem_s[k];
			assign root_i = root_s[k];
		end

		assign trial = (66'(root_i) << (Bit + 1)) + (66'(1) << (2 * Bit));
		assign take  = 66'(rem_i) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[k+1]  <= ctx_i;
				rem_s[k+1]  <= take ? 64'(66'(rem_i) - trial) : rem_i;
				root_s[k+1] <= take ? (root_i | (32'(1) << Bit)) : root_i;
			end
		end
	end

	assign out_valid = v_s[SQ_STEPS];
	assign out_ctx   = ctx_s[SQ_STEPS];
	assign root      = root_s[SQ_STEPS];

endmodule

`default_nettype wire

// ----- design/cps_div.sv -----
`default_nettype none

module cps_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire cps_pkg::ctx_t      in_ctx,
	input  wire logic [64:0]        num_x,
	input  wire logic [64:0]        num_y,
	input  wire logic [31:0]        den,
	output logic                    out_valid,
	output cps_pkg::ctx_t           out_ctx,
	output logic [32:0]             quo_x,
	output logic [32:0]             quo_y
);
	import cps_pkg::*;

	logic              v_s   [1:DIV_STEPS];
	ctx_t              ctx_s [1:DIV_STEPS];
	logic [NUM_W-1:0]  rx_s  [1:DIV_STEPS];
	logic [NUM_W-1:0]  ry_s  [1:DIV_STEPS];
	logic [32:0]       qx_s  [1:DIV_STEPS];
	logic [32:0]       qy_s  [1:DIV_STEPS];
	logic [31:0]       d_s   [1:DIV_STEPS];

	// Two restoring dividers side by side, one quotient bit per stage.
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int unsigned Bit = DIV_STEPS - 1 - k;
		logic             v_i;
		ctx_t             ctx_i;
		logic [NUM_W-1:0] rx_i, ry_i, dsh;
		logic [32:0]      qx_i, qy_i;
		logic [31:0]      d_i;
		logic             tx, ty;

		if (k == 0) begin : g_first
			assign v_i   = in_valid;
			assign ctx_i = in_ctx;
			assign rx_i  = num_x;
			assign ry_i  = num_y;
			assign qx_i  = '0;
			assign qy_i  = '0;
			assign d_i   = den;
		end else begin : g_next
			assign v_i   = v_s[k];
			assign ctx_i = ctx_s[k];
			assign rx_i  = rx_s[k];
			assign ry_i  = ry_s[k];
			assign qx_i  = qx_s[k];
			assign qy_i  = qy_s[k];
			assign d_i   = d_s[k];
		end

		assign dsh = NUM_W'(d_i) << Bit;
		assign tx  = rx_i >= dsh;
		assign ty  = ry_i >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[k+1] <= ctx_i;
				d_s[k+1]   <= d_i;
				rx_s[k+1]  <= tx ? (rx_i - dsh) : rx_i;
				ry_s[k+1]  <= ty ? (ry_i - dsh) : ry_i;
				qx_s[k+1]  <= tx ? (qx_i | (33'(1) << Bit)) : qx_i;
				qy_s[k+1]  <= ty ? (qy_i | (33'(1) << Bit)) : qy_i;
			end
		end
	end

	assign out_valid = v_s[DIV_STEPS];
	assign out_ctx   = ctx_s[DIV_STEPS];
	assign quo_x     = qx_s[DIV_STEPS];
	assign quo_y     = qy_s[DIV_STEPS];

endmodule

`default_nettype wire

// ----- design/collider_pair_overlap_separation.sv -----
`default_nettype none

// Channel  Handshake              Payload
// input    in_valid / in_ready    mover_* and fixed_* fields
// output   out_valid / out_ready  overlap, push_x, push_y
//
// One pair enters per cycle while in_ready is high; each pair passes through
// 5 geometry stages, 32 root stages, one scaling stage, 33 divide stages and
// the output register.
// Reset clears every valid bit and the skid entry; data registers are not reset.
// A stalled output parks one result in the skid entry and freezes the pipeline,
// so in_ready is a register and nothing is dropped or repeated.

module collider_pair_overlap_separation (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         mover_kind,
	input  wire logic signed [31:0] mover_center_x,
	input  wire logic signed [31:0] mover_center_y,
	input  wire logic [30:0]        mover_extent_x,
	input  wire logic [30:0]        mover_extent_y,
	input  wire logic [1:0]         fixed_kind,
	input  wire logic signed [31:0] fixed_center_x,
	input  wire logic signed [31:0] fixed_center_y,
	input  wire logic [30:0]        fixed_extent_x,
	input  wire logic [30:0]        fixed_extent_y,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    overlap,
	output logic signed [31:0]      push_x,
	output logic signed [31:0]      push_y
);
	import cps_pkg::*;

	logic               en;
	logic               fr_v, sq_v, dv_v;
	ctx_t               fr_ctx, sq_ctx, dv_ctx;
	logic [63:0]        fr_rad;
	logic [31:0]        sq_root;
	logic               v_sm;
	ctx_t               ctx_sm;
	logic [64:0]        numx_sm, numy_sm;
	logic [31:0]        len_sm;
	logic [32:0]        sep_c;
	ctx_t               ctx_c;
	logic [32:0]        qx, qy;
	logic signed [35:0] tx, ty, fx, fy;
	logic               hit_c;
	logic signed [31:0] px_c, py_c;
	logic               skid_q, skid_hit_q, out_free;
	logic signed [31:0] skid_px_q, skid_py_q;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -36'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// The whole pipeline moves while the skid entry is empty.
	assign en       = !skid_q;
	assign in_ready = en;

	cps_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (in_valid),
		.mover_kind     (mover_kind),
		.mover_center_x (mover_center_x),
		.mover_center_y (mover_center_y),
		.mover_extent_x (mover_extent_x),
		.mover_extent_y (mover_extent_y),
		.fixed_kind     (fixed_kind),
		.fixed_center_x (fixed_center_x),
		.fixed_center_y (fixed_center_y),
		.fixed_extent_x (fixed_extent_x),
		.fixed_extent_y (fixed_extent_y),
		.out_valid      (fr_v),
		.out_ctx        (fr_ctx),
		.out_rad        (fr_rad)
	);

	cps_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_v),
		.in_ctx    (fr_ctx),
		.rad       (fr_rad),
		.out_valid (sq_v),
		.out_ctx   (sq_ctx),
		.root      (sq_root)
	);

	// Scale each offset by the remaining reach before the divide.
	always_comb begin
		sep_c          = 33'(sq_ctx.r) - 33'(sq_root);
		ctx_c          = sq_ctx;
		ctx_c.len_zero = (sq_root == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sm <= 1'b0;
		end else if (en) begin
			v_sm <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_sm  <= ctx_c;
			len_sm  <= sq_root;
			numx_sm <= 65'(sq_ctx.a) * 65'(sep_c);
			numy_sm <= 65'(sq_ctx.b) * 65'(sep_c);
		end
	end

	cps_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_sm),
		.in_ctx    (ctx_sm),
		.num_x     (numx_sm),
		.num_y     (numy_sm),
		.den       (len_sm),
		.out_valid (dv_v),
		.out_ctx   (dv_ctx),
		.quo_x     (qx),
		.quo_y     (qy)
	);

	// Choose axis or round push, apply signs and the mover/fixed swap, saturate.
	always_comb begin
		if (dv_ctx.rnd) begin
			if (dv_ctx.len_zero) begin
				tx = '0;
				ty = '0;
			end else begin
				tx = dv_ctx.neg_x ? -signed'(36'(qx)) : signed'(36'(qx));
				ty = dv_ctx.neg_y ? -signed'(36'(qy)) : signed'(36'(qy));
			end
		end else begin
			tx = 36'(dv_ctx.ax_px);
			ty = 36'(dv_ctx.ax_py);
		end
		fx    = dv_ctx.flip ? -tx : tx;
		fy    = dv_ctx.flip ? -ty : ty;
		hit_c = dv_ctx.hit;
		px_c  = hit_c ? sat32(fx) : '0;
		py_c  = hit_c ? sat32(fy) : '0;
	end

	// Output register with a one-entry skid behind it.
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_q    <= 1'b0;
		end else if (out_free) begin
			if (skid_q) begin
				out_valid <= 1'b1;
				skid_q    <= 1'b0;
			end else begin
				out_valid <= dv_v;
			end
		end else if (en && dv_v) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_q) begin
				overlap <= skid_hit_q;
				push_x  <= skid_px_q;
				push_y  <= skid_py_q;
			end else begin
				overlap <= hit_c;
				push_x  <= px_c;
				push_y  <= py_c;
			end
		end else if (en && dv_v) begin
			skid_hit_q <= hit_c;
			skid_px_q  <= px_c;
			skid_py_q  <= py_c;
		end
	end

endmodule

`default_nettype wire
